FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked at every clock edge, also while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

// Assertion that is switched off while the active-low reset is applied.
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/upd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder package
// Types, character constants and hex helper functions for the decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

	typedef logic [7:0] byte_t;

	// Escape introducer character.
	localparam byte_t PCT_CHAR = 8'h25;

	// Most bytes that one transaction on the input can produce.
	localparam int unsigned MAX_RES = 3;

	// What the decoder holds between input bytes.
	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PCT   = 2'd1,
		PEND_DIGIT = 2'd2
	} pend_t;

	// A group of up to three result bytes produced by one input byte.
	typedef struct packed {
		logic [1:0]                 count;
		logic [MAX_RES-1:0][7:0]    data;
		logic                       last;
	} grp_t;

	function automatic logic is_hex(input byte_t c);
		return (c >= 8'h30 && c <= 8'h39) ||
		       (c >= 8'h41 && c <= 8'h46) ||
		       (c >= 8'h61 && c <= 8'h66);
	endfunction

	// Nibble value of a hex digit; zero for anything else.
	function automatic logic [3:0] hex_val(input byte_t c);
		byte_t t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

endpackage

FILE: rtl/upd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder input channel
// Valid/ready channel that carries one raw path byte per transaction.
// ----------------------------------------------------------------------------
interface upd_in_if;
	import upd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: rtl/upd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decoder output channel
// Valid/ready channel that carries one decoded byte per transaction.
// ----------------------------------------------------------------------------
interface upd_out_if;
	import upd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_run_end;
	logic  out_last;

	modport source (output valid, output out_byte, output out_run_end, output out_last,
		input ready);
	modport sink (input valid, input out_byte, input out_run_end, input out_last,
		output ready);
endinterface

FILE: rtl/upd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder byte logic
// Turns one input byte and the pending state into a result group and the
// pending state for the next byte.
// ----------------------------------------------------------------------------
module upd_decode (
	input  upd_pkg::pend_t pend,
	input  upd_pkg::byte_t held,
	input  upd_pkg::byte_t in_byte,
	input  logic           in_last,
	output upd_pkg::pend_t pend_nxt,
	output upd_pkg::byte_t held_nxt,
	output upd_pkg::grp_t  res
);
	import upd_pkg::*;

	logic  digit;
	logic  is_pct;
	pend_t pend_mid;
	byte_t held_mid;

	// Appends one byte to a group unless it is already full.
	function automatic grp_t push(input grp_t g, input byte_t b);
		grp_t r;
		r = g;
		if (g.count < 2'(MAX_RES)) begin
			r.data[g.count] = b;
			r.count = g.count + 2'd1;
		end
		return r;
	endfunction

	assign digit  = is_hex(in_byte);
	assign is_pct = (in_byte == PCT_CHAR);

	// Next state. pend_mid is the state before an end-of-path flush.
	always_comb begin
		pend_mid = is_pct ? PEND_PCT : PEND_NONE;
		held_mid = held;
		case (pend)
			PEND_PCT: begin
				if (digit) begin
					pend_mid = PEND_DIGIT;
					held_mid = in_byte;
				end
			end
			PEND_DIGIT: begin
				if (digit) begin
					pend_mid = PEND_NONE;
				end
			end
			default: begin
			end
		endcase
		pend_nxt = in_last ? PEND_NONE : pend_mid;
		held_nxt = in_last ? 8'h00 : held_mid;
	end

	// Result bytes, in the order they leave the block.
	always_comb begin
		res = '0;
		case (pend)
			PEND_PCT: begin
				if (!digit) begin
					res = push(res, PCT_CHAR);
					if (!is_pct) begin
						res = push(res, in_byte);
					end
				end
			end
			PEND_DIGIT: begin
				if (digit) begin
					res = push(res, {hex_val(held), hex_val(in_byte)});
				end else begin
					res = push(res, PCT_CHAR);
					res = push(res, held);
					if (!is_pct) begin
						res = push(res, in_byte);
					end
				end
			end
			default: begin
				if (!is_pct) begin
					res = push(res, in_byte);
				end
			end
		endcase
		if (in_last) begin
			if (pend_mid == PEND_PCT) begin
				res = push(res, PCT_CHAR);
			end else if (pend_mid == PEND_DIGIT) begin
				res = push(res, PCT_CHAR);
				res = push(res, held_mid);
			end
		end
		res.last = in_last;
	end

endmodule

FILE: rtl/upd_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder result register
// Holds one result group and hands its bytes out one per transaction.
// ----------------------------------------------------------------------------
module upd_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  upd_pkg::grp_t grp,
	output logic          free,
	upd_out_if.source     out_ch
);
	import upd_pkg::*;

	logic       grp_valid_q;
	grp_t       grp_q;
	logic [1:0] pos_q;
	logic       cur_last;
	logic       take;

	assign cur_last = (pos_q == grp_q.count - 2'd1);
	assign take     = grp_valid_q && out_ch.ready;
	assign free     = !grp_valid_q || (take && cur_last);

	assign out_ch.valid       = grp_valid_q;
	assign out_ch.out_run_end = cur_last;
	assign out_ch.out_last    = cur_last && grp_q.last;

	always_comb begin
		case (pos_q)
			2'd1:    out_ch.out_byte = grp_q.data[1];
			2'd2:    out_ch.out_byte = grp_q.data[2];
			default: out_ch.out_byte = grp_q.data[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			pos_q       <= 2'd0;
		end else if (load) begin
			grp_valid_q <= 1'b1;
			pos_q       <= 2'd0;
		end else if (take && cur_last) begin
			grp_valid_q <= 1'b0;
		end else if (take) begin
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_q <= grp;
		end
	end

endmodule

FILE: rtl/url_percent_decoder.sv
// Path: an accepted byte is registered in the input register, and its decoded bytes
// are loaded into the result register, from which the output channel is fed.
// Throughput: one input byte per cycle while each byte yields at most one result and
// the output does not stall; each result of a larger group holds the single output port.
// Reset: arst_n clears the pending escape, the input register and the result register.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder for percent-escaped URL paths, one byte per transaction.
// ----------------------------------------------------------------------------
module url_percent_decoder (
	input  logic      clk,
	input  logic      arst_n,
	upd_in_if.sink    in_ch,
	upd_out_if.source out_ch
);
	import upd_pkg::*;

	// The design has two register ranks. The input register holds the
	// accepted byte. Between it and the result register sits the byte
	// logic, which looks at the pending state (a held '%' and possibly one
	// hex digit) and produces a group of zero to three output bytes. The
	// result register then drains that group one byte per output
	// transaction, so the output handshake is always fed from flops.

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// Pending escape state, updated when a byte leaves the input register.
	pend_t pend_q;
	byte_t held_q;

	pend_t pend_nxt;
	byte_t held_nxt;
	grp_t  grp;
	logic  grp_free;
	logic  advance;
	logic  in_take;

	// A byte moves on as soon as the result register can take its group.
	// A group of zero bytes still moves the byte along and updates the
	// pending state, but nothing is loaded into the result register.
	assign advance     = valid_s1 && grp_free;
	assign in_ch.ready = !valid_s1 || grp_free;
	assign in_take     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
	end

	// The pending state returns to empty after the last byte of a path,
	// which the byte logic already folds into pend_nxt and held_nxt.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= 8'h00;
		end else if (advance) begin
			pend_q <= pend_nxt;
			held_q <= held_nxt;
		end
	end

	upd_decode u_decode (
		.pend     (pend_q),
		.held     (held_q),
		.in_byte  (byte_s1),
		.in_last  (last_s1),
		.pend_nxt (pend_nxt),
		.held_nxt (held_nxt),
		.res      (grp)
	);

	upd_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && (grp.count != 2'd0)),
		.grp    (grp),
		.free   (grp_free),
		.out_ch (out_ch)
	);

endmodule

FILE: rtl/upd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_run_end,
	input logic       out_last
);

	// A stalled result keeps its value until it is taken.
	`ASSERT_RUN(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_end) && $stable(out_last), "stalled result changed")

	// Nothing is offered while reset is applied.
	`ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid, "result offered in reset")

	// The input only stalls behind a result that waits on the output.
	`ASSERT_ALWAYS(a_stall_cause, clk, !in_ready |-> out_valid, "input stalled with no result waiting")

	// The remaining bytes of one input byte's group follow without a gap.
	`ASSERT_RUN(a_run_cont, clk, arst_n, out_valid && out_ready && !out_run_end |=> out_valid, "gap inside a result group")

	// The end of a path is always the end of its group.
	`ASSERT_RUN(a_last_end, clk, arst_n, out_valid && out_last |-> out_run_end, "path end inside a group")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_byte    (out_ch.out_byte),
	.out_run_end (out_ch.out_run_end),
	.out_last    (out_ch.out_last)
);

FILE: bench/url_percent_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Feeds encoded URL paths into the decoder one byte per transaction and
// checks every decoded byte and its run-end and last flags against a
// behavioral model of the escape decoding. Directed paths come first. Random
// paths follow under three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
	import upd_pkg::*;

	// A path as a list of raw bytes; the final one goes out with in_last set.
	typedef byte_t byte_q_t[$];

	// One decoded byte as the output channel should present it.
	typedef struct packed {
		byte_t data;
		logic  run_end;
		logic  last;
	} decoded_t;

	// The run stops if this many cycles pass with no transaction on either side.
	localparam int unsigned STALL_LIMIT = 4000;
	// Cycles to wait after the last expected byte so that stray output shows up.
	localparam int unsigned SETTLE_CYCLES = 8;

	logic clk;
	logic arst_n;

	upd_in_if  in_ch();
	upd_out_if out_ch();

	url_percent_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Decoded bytes that the block still owes us, oldest first.
	decoded_t pending_decoded[$];

	// Escape state as the model tracks it between input bytes.
	pend_t escape_state;
	byte_t held_digit;

	// Chance in percent that a side sits idle in a given cycle.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	int errors;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Bit 4 flags a hex digit; bits 3:0 carry its value. For '0'..'9' the low
	// nibble is already the value, and for 'A'..'F' and 'a'..'f' the low nibble
	// is 1..6, so adding nine gives 10..15.
	function automatic logic [4:0] nibble_of(input byte_t c);
		logic [4:0] r;
		r = 5'd0;
		if (c inside {[8'h30:8'h39]}) begin
			r = {1'b1, c[3:0]};
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Works out what one accepted input byte produces and queues it.
	function automatic void predict_decoded(input byte_t b, input logic lst);
		byte_t      res[$];
		logic [4:0] nb;
		logic [4:0] nh;
		logic       plain;
		int         n;
		nb    = nibble_of(b);
		plain = 1'b0;
		case (escape_state)
			PEND_PCT: begin
				if (nb[4]) begin
					held_digit   = b;
					escape_state = PEND_DIGIT;
				end else begin
					// Broken escape: the '%' goes out as is and the byte is looked
					// at again from scratch.
					res.push_back(PCT_CHAR);
					plain = 1'b1;
				end
			end
			PEND_DIGIT: begin
				if (nb[4]) begin
					nh = nibble_of(held_digit);
					res.push_back({nh[3:0], nb[3:0]});
					escape_state = PEND_NONE;
				end else begin
					res.push_back(PCT_CHAR);
					res.push_back(held_digit);
					plain = 1'b1;
				end
			end
			default: begin
				plain = 1'b1;
			end
		endcase
		if (plain) begin
			escape_state = PEND_NONE;
			if (b == PCT_CHAR) begin
				escape_state = PEND_PCT;
			end else begin
				res.push_back(b);
			end
		end
		// End of path flushes whatever escape is still open as literal bytes.
		if (lst) begin
			if (escape_state == PEND_PCT) begin
				res.push_back(PCT_CHAR);
			end else if (escape_state == PEND_DIGIT) begin
				res.push_back(PCT_CHAR);
				res.push_back(held_digit);
			end
			escape_state = PEND_NONE;
			held_digit   = 8'h00;
		end
		n = res.size();
		for (int i = 0; i < n; i++) begin
			pending_decoded.push_back('{res[i], i == n - 1, lst && (i == n - 1)});
		end
	endfunction

	// Offers one byte and returns at the edge where it is taken. The valid
	// line is only lowered when a gap is inserted, so back-to-back
	// transactions never lower and raise it in the same step.
	task automatic send_byte(input byte_t b, input logic lst);
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid   <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.in_last <= lst;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
		predict_decoded(b, lst);
	endtask

	task automatic send_path(input byte_q_t p);
		foreach (p[i]) begin
			send_byte(p[i], i == p.size() - 1);
		end
	endtask

	// Holds the input back until the block has delivered everything it owes.
	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		while (pending_decoded.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	function automatic byte_t rand_hex_digit();
		int unsigned k;
		k = $urandom_range(21);
		if (k < 10) begin
			return byte_t'(8'h30 + k);
		end else if (k < 16) begin
			return byte_t'(8'h41 + k - 10);
		end
		return byte_t'(8'h61 + k - 16);
	endfunction

	function automatic byte_t rand_non_hex();
		byte_t c;
		do begin
			c = byte_t'($urandom_range(255));
		end while (nibble_of(c) != 5'd0);
		return c;
	endfunction

	// A random path built mostly from well-formed pieces: plain bytes and
	// complete escapes, with broken escapes and raw noise mixed in. Now and
	// then the path is cut short so that it may end inside an escape.
	function automatic byte_q_t random_path();
		byte_q_t     p;
		int unsigned kind;
		int unsigned segs;
		byte_t       c;
		segs = $urandom_range(8, 1);
		for (int s = 0; s < segs; s++) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				c = byte_t'($urandom_range(255));
				p.push_back(c == PCT_CHAR ? 8'h2f : c);
			end else if (kind < 65) begin
				p.push_back(PCT_CHAR);
				p.push_back(rand_hex_digit());
				p.push_back(rand_hex_digit());
			end else if (kind < 75) begin
				p.push_back(PCT_CHAR);
				p.push_back(rand_non_hex());
			end else if (kind < 85) begin
				p.push_back(PCT_CHAR);
				p.push_back(rand_hex_digit());
				p.push_back(rand_non_hex());
			end else if (kind < 92) begin
				p.push_back(PCT_CHAR);
			end else begin
				p.push_back(byte_t'($urandom_range(255)));
			end
		end
		if ($urandom_range(99) < 20) begin
			segs = $urandom_range(p.size(), 1);
			while (p.size() > segs) begin
				void'(p.pop_back());
			end
		end
		return p;
	endfunction

	// Hand-picked paths: both letter cases, the byte extremes on both sides,
	// a '%' that breaks an escape and starts a new one, and every kind of
	// open escape at the end of a path.
	task automatic test_directed_paths();
		byte_q_t p;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		p = {PCT_CHAR, 8'h34, 8'h31};                // "%41" gives 'A'
		send_path(p);
		p = {PCT_CHAR, 8'h66, 8'h46};                // "%fF" gives 0xFF
		send_path(p);
		p = {PCT_CHAR, 8'h30, 8'h30};                // "%00" gives NUL
		send_path(p);
		p = {PCT_CHAR, PCT_CHAR, 8'h34, 8'h31};      // '%' then 'A'
		send_path(p);
		p = {PCT_CHAR, 8'h37, 8'h7a, 8'h2f};         // broken after one digit
		send_path(p);
		p = {PCT_CHAR, 8'h39, PCT_CHAR};             // three bytes on the last one
		send_path(p);
		p = {PCT_CHAR};                              // lone '%' as the whole path
		send_path(p);
		p = {PCT_CHAR, 8'h61};                       // digit left open at the end
		send_path(p);
		p = {8'h00, 8'hff, 8'h3f, 8'h3b};            // NUL, 0xFF, '?' and ';'
		send_path(p);
	endtask

	// Pauses the sender with an escape half received, so that the held state
	// has to survive an empty pipeline.
	task automatic test_hold_mid_escape();
		send_idle_pct = 10;
		recv_idle_pct = 50;
		send_byte(PCT_CHAR, 1'b0);
		send_byte(8'h34, 1'b0);
		hold_until_drained();
		send_byte(8'h32, 1'b1);
		send_byte(8'h2f, 1'b0);
		send_byte(PCT_CHAR, 1'b0);
		hold_until_drained();
		send_byte(8'h78, 1'b1);
	endtask

	task automatic test_random_paths(input int unsigned snd_idle, input int unsigned rcv_idle,
		input int unsigned n_items);
		byte_q_t     p;
		int unsigned sent;
		send_idle_pct = snd_idle;
		recv_idle_pct = rcv_idle;
		sent = 0;
		while (sent < n_items) begin
			p = random_path();
			send_path(p);
			sent += p.size();
		end
	endtask

	// Receiver side: ready is redrawn every cycle from the current idle rate.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every output transaction is matched against the oldest byte still owed.
	always @(posedge clk) begin : result_check
		decoded_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_decoded.size() == 0) begin
				$display("%0t: unexpected output byte %02h (run_end %b, last %b)", $time,
					out_ch.out_byte, out_ch.out_run_end, out_ch.out_last);
				errors++;
			end else begin
				want = pending_decoded.pop_front();
				if (out_ch.out_byte !== want.data) begin
					$display("%0t: out_byte expected %02h, got %02h", $time, want.data,
						out_ch.out_byte);
					errors++;
				end
				if (out_ch.out_run_end !== want.run_end) begin
					$display("%0t: out_run_end expected %b, got %b", $time, want.run_end,
						out_ch.out_run_end);
					errors++;
				end
				if (out_ch.out_last !== want.last) begin
					$display("%0t: out_last expected %b, got %b", $time, want.last,
						out_ch.out_last);
					errors++;
				end
			end
		end
	end

	// Watchdog: ends the run if both channels stay quiet for too long.
	initial begin : stall_watch
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no transaction for %0d cycles, %0d bytes still owed", $time,
			STALL_LIMIT, pending_decoded.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		errors        = 0;
		escape_state  = PEND_NONE;
		held_digit    = 8'h00;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b1;
		in_ch.valid   = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.in_last = 1'b0;
		out_ch.ready  = 1'b0;
		// Reset falls just after time zero so that every flop sees a clean edge.
		#1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_paths();
		test_hold_mid_escape();
		// Slow receiver, then slow sender, then both at full rate.
		test_random_paths(38, 87, 145);
		test_random_paths(87, 38, 145);
		test_random_paths(0, 0, 145);

		in_ch.valid <= 1'b0;
		while (pending_decoded.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
